/* hdl/sgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types and constants for the sequence gap detector: request layout,
// opcodes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package sgd_pkg;

    // fixed field widths of the request and result
    localparam int SEQ_PORT_W   = 32;
    localparam int THRESH_W     = 16;
    localparam int STATUS_W     = 3;
    localparam int GAP_COUNT_W  = 32;
    localparam int LOST_W       = 64;

    // request opcodes
    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ARMED     = 3'd0,
        ST_IN_ORDER  = 3'd1,
        ST_GAP       = 3'd2,
        ST_SMALL_GAP = 3'd3,
        ST_BEHIND    = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    // one registered request
    typedef struct packed {
        t_opcode                 opcode;
        logic [SEQ_PORT_W-1:0]   seq_num;
    } t_request;

endpackage

/* hdl/sgd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_in_stage
// Input register for requests. Holds one request and passes it on when the
// result side can take it; stalls the sender only while full and blocked.
// ----------------------------------------------------------------------------
module sgd_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  sgd_pkg::t_request       i_request,
    input  logic                    i_advance_ok,
    output logic                    o_advance,
    output sgd_pkg::t_request       o_request
);
    import sgd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_request r_request;
    logic     w_take;

    // request moves on when the result register is free this cycle
    assign o_advance  = r_valid && i_advance_ok;
    assign o_in_stall = r_valid && !i_advance_ok;
    assign w_take     = i_in_valid && !o_in_stall;
    assign o_request  = r_request;

    // occupancy of the input register
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_request <= i_request;
        end
    end

endmodule

/* hdl/sgd_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_tracker
// Sequence tracking state, gap statistics and the result register. One
// compare and subtract per request decides the status and updates state.
// ----------------------------------------------------------------------------
module sgd_tracker #(
    parameter int SEQ_W = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_write,
    input  logic [sgd_pkg::THRESH_W-1:0]        i_cfg_data,
    input  logic                                i_load,
    input  sgd_pkg::t_request                   i_request,
    input  logic                                i_out_stall,
    output logic                                o_load_ok,
    output logic                                o_out_valid,
    output logic                                o_gap_detected,
    output logic [sgd_pkg::STATUS_W-1:0]        o_status,
    output logic [sgd_pkg::SEQ_PORT_W-1:0]      o_gap_len,
    output logic [sgd_pkg::GAP_COUNT_W-1:0]     o_gap_total,
    output logic [sgd_pkg::LOST_W-1:0]          o_total_lost,
    output logic [sgd_pkg::SEQ_PORT_W-1:0]      o_last_gap
);
    import sgd_pkg::*;

    localparam int CMP_W = (SEQ_W > THRESH_W) ? SEQ_W : THRESH_W;

    // configuration and tracking state
    logic [THRESH_W-1:0]    r_threshold;
    logic                   r_armed;
    logic                   n_armed;
    logic [SEQ_W-1:0]       r_expected;
    logic [SEQ_W-1:0]       n_expected;
    logic [GAP_COUNT_W-1:0] r_gap_count;
    logic [GAP_COUNT_W-1:0] n_gap_count;
    logic [LOST_W-1:0]      r_lost;
    logic [LOST_W-1:0]      n_lost;
    logic [SEQ_W-1:0]       r_last_gap;
    logic [SEQ_W-1:0]       n_last_gap;

    // result register
    logic                   r_out_valid;
    logic                   r_gap_detected;
    logic                   n_gap_detected;
    t_status                r_status;
    t_status                n_status;
    logic [SEQ_W-1:0]       r_gap_len;
    logic [SEQ_W-1:0]       n_gap_len;

    logic [SEQ_W-1:0]       w_num;
    logic [SEQ_W-1:0]       w_diff;
    logic [SEQ_W-1:0]       w_num_inc;

    assign o_load_ok = !r_out_valid || !i_out_stall;
    assign w_num     = SEQ_W'(i_request.seq_num);
    assign w_diff    = w_num - r_expected;
    assign w_num_inc = w_num + SEQ_W'(1);

    // per-request decision and state update
    always_comb begin
        n_armed        = r_armed;
        n_expected     = r_expected;
        n_gap_count    = r_gap_count;
        n_lost         = r_lost;
        n_last_gap     = r_last_gap;
        n_gap_detected = 1'b0;
        n_gap_len      = '0;
        n_status       = ST_CLEARED;
        if (i_request.opcode == OP_CLEAR) begin
            n_armed     = 1'b0;
            n_expected  = '0;
            n_gap_count = '0;
            n_lost      = '0;
            n_last_gap  = '0;
            n_status    = ST_CLEARED;
        end else if (!r_armed) begin
            n_armed    = 1'b1;
            n_expected = w_num_inc;
            n_status   = ST_ARMED;
        end else if (w_num == r_expected) begin
            n_expected = w_num_inc;
            n_status   = ST_IN_ORDER;
        end else if (w_num > r_expected) begin
            n_expected = w_num_inc;
            n_gap_len  = w_diff;
            if (CMP_W'(w_diff) >= CMP_W'(r_threshold)) begin
                n_gap_count    = r_gap_count + GAP_COUNT_W'(1);
                n_lost         = r_lost + LOST_W'(w_diff);
                n_last_gap     = w_diff;
                n_gap_detected = 1'b1;
                n_status       = ST_GAP;
            end else begin
                n_status = ST_SMALL_GAP;
            end
        end else begin
            n_expected = w_num_inc;
            n_status   = ST_BEHIND;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_W'(1);
            r_armed     <= 1'b0;
            r_expected  <= '0;
            r_gap_count <= '0;
            r_lost      <= '0;
            r_last_gap  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_threshold <= i_cfg_data;
            end
            if (i_load) begin
                r_armed     <= n_armed;
                r_expected  <= n_expected;
                r_gap_count <= n_gap_count;
                r_lost      <= n_lost;
                r_last_gap  <= n_last_gap;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gap_detected <= n_gap_detected;
            r_status       <= n_status;
            r_gap_len      <= n_gap_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gap_detected = r_gap_detected;
    assign o_status       = r_status;
    assign o_gap_len      = SEQ_PORT_W'(r_gap_len);
    assign o_gap_total    = r_gap_count;
    assign o_total_lost   = r_lost;
    assign o_last_gap     = SEQ_PORT_W'(r_last_gap);

endmodule

/* hdl/sequence_gap_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_gap_detector_unit
// Follows packet sequence numbers and reports forward gaps, reordered or
// duplicate packets and running loss statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_stall with i_opcode and
//   i_seq_num. A request is taken at a clock edge with valid high
//   and stall low. Opcode check tracks the number, opcode clear resets the
//   tracker and statistics (the threshold is kept).
//   Result channel: o_out_valid / i_out_stall, one result per request, in
//   order. Statistics fields show the values after the update.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the gap
//   threshold. Ready is always high; write only while no request is in flight.
//   The request sits in the input register, and the result register loads
//   from it when that register is free. Throughput: one request per cycle
//   while the receiver does not stall, set by the single compare and
//   subtract between the two registers.
//   Reset: synchronous, active low; tracker disarmed, statistics zero,
//   threshold one, both pipeline registers empty.
//   Back pressure: while the receiver stalls, the result holds; the input
//   register still fills, and the sender is stalled only when both are full.
// ----------------------------------------------------------------------------
module sequence_gap_detector_unit #(
    parameter int SEQUENCE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [sgd_pkg::SEQ_PORT_W-1:0]      i_seq_num,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_gap_detected,
    output logic [sgd_pkg::STATUS_W-1:0]        o_status,
    output logic [sgd_pkg::SEQ_PORT_W-1:0]      o_gap_len,
    output logic [sgd_pkg::GAP_COUNT_W-1:0]     o_gap_total,
    output logic [sgd_pkg::LOST_W-1:0]          o_total_lost,
    output logic [sgd_pkg::SEQ_PORT_W-1:0]      o_last_gap,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgd_pkg::THRESH_W-1:0]        i_cfg_data
);
    import sgd_pkg::*;

    // tracked width: header numbers are truncated or zero extended to it
    localparam int SEQ_W = SEQUENCE_BITS;

    t_request w_in_request;
    t_request w_s1_request;
    logic     w_advance;
    logic     w_load_ok;

    assign w_in_request.opcode  = t_opcode'(i_opcode);
    assign w_in_request.seq_num = i_seq_num;
    assign o_cfg_ready          = 1'b1;

    // input register
    sgd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_request    (w_in_request),
        .i_advance_ok (w_load_ok),
        .o_advance    (w_advance),
        .o_request    (w_s1_request)
    );

    // tracking logic and result register
    sgd_tracker #(
        .SEQ_W (SEQ_W)
    ) u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_load         (w_advance),
        .i_request      (w_s1_request),
        .i_out_stall    (i_out_stall),
        .o_load_ok      (w_load_ok),
        .o_out_valid    (o_out_valid),
        .o_gap_detected (o_gap_detected),
        .o_status       (o_status),
        .o_gap_len      (o_gap_len),
        .o_gap_total    (o_gap_total),
        .o_total_lost   (o_total_lost),
        .o_last_gap     (o_last_gap)
    );

endmodule
